[hdl/ffba_pkg.sv]
package ffba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int ENTRY_W = $clog2(MAX_BLOCKS);
    localparam int LINK_W = ENTRY_W + 1;
    localparam logic [LINK_W-1:0] NONE_ENTRY = LINK_W'(MAX_BLOCKS);

    localparam logic [16:0] HEAP_BYTES = 17'd65536;
    localparam logic [16:0] HEADER_BYTES = 17'd24;
    localparam logic [16:0] MIN_BLOCK_BYTES = 17'd32;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef struct packed {
        logic [15:0]       offset;
        logic [16:0]       size;
        logic              is_free;
        logic [LINK_W-1:0] next;
    } hdr_t;

endpackage

[hdl/ffba_ram.sv]
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/first_fit_block_allocator.sv]
// first-fit block allocator over a 64 KiB arena, up to 256 block headers
// input channel (in_valid/in_ready): op, request_bytes, free_address; one
// request is taken at a time and in_ready is low while it is being served
// output channel (out_valid/out_ready): payload_address and status, one
// transaction per request, held in an output register
// config channel (cfg_valid/cfg_ready): arena_limit, always ready
// null requests skip the walk and go straight to the result; a walk
// visits each header with one header memory read and one evaluate;
// each header visit is one read of the single-port-read header memory
// followed by one compare of size (alloc) or offset (free)
// a split, bump or merge adds 1 or 2 header memory writes at the end
// reset empties the list, zeroes the arena top, refills the spare entry pool
// and sets arena_limit to 65536; no clearing pass is needed
// when the receiver stalls, the finished result waits in the output
// register and the block takes the next request; that request's result then
// waits inside the block until the output register is free
module first_fit_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [16:0] request_bytes,
    input  logic [15:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] payload_address,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] arena_limit
);
    import ffba_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WALK      = 4'd1;
    localparam logic [3:0] S_EVAL      = 4'd2;
    localparam logic [3:0] S_SPLIT_POP = 4'd3;
    localparam logic [3:0] S_SPLIT_WR  = 4'd4;
    localparam logic [3:0] S_BUMP      = 4'd5;
    localparam logic [3:0] S_BUMP_POP  = 4'd6;
    localparam logic [3:0] S_BUMP_WR   = 4'd7;
    localparam logic [3:0] S_FREE_NX   = 4'd8;
    localparam logic [3:0] S_FIN       = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [16:0]         limit_reg, limit_next;
    logic                op_reg, op_next;
    logic [17:0]         need_reg, need_next;
    logic [15:0]         faddr_reg, faddr_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   steps_reg, steps_next;
    hdr_t                cur_hdr_reg, cur_hdr_next;
    logic [ENTRY_W-1:0]  new_reg, new_next;
    logic [ENTRY_W-1:0]  pop_idx_reg, pop_idx_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   tail_reg, tail_next;
    logic [16:0]         top_reg, top_next;
    logic [LINK_W-1:0]   spare_cnt_reg, spare_cnt_next;
    logic [MAX_BLOCKS-1:0] spare_vld_reg, spare_vld_next;
    logic [15:0]         res_addr_reg, res_addr_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_addr_reg, out_addr_next;
    logic [1:0]          out_status_reg, out_status_next;

    logic                hdr_we, hdr_re;
    logic [ENTRY_W-1:0]  hdr_waddr, hdr_raddr;
    hdr_t                hdr_wdata, hdr_rdata;
    logic                sp_we, sp_re;
    logic [ENTRY_W-1:0]  sp_waddr, sp_raddr;
    logic [ENTRY_W-1:0]  sp_wdata, sp_rdata;

    logic [ENTRY_W-1:0]  spare_val;
    logic [16:0]         lim;
    logic [18:0]         bump_end;
    logic [16:0]         left;
    logic [16:0]         need17;
    logic [16:0]         pay17;

    ffba_ram #(.WIDTH($bits(hdr_t)), .DEPTH(MAX_BLOCKS)) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .re    (hdr_re),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_spare_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (sp_re),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign payload_address = out_addr_reg;
    assign status = out_status_reg;

    // unpushed stack slots hold their reset entry number
    assign spare_val = spare_vld_reg[pop_idx_reg] ? sp_rdata
                     : ENTRY_W'(MAX_BLOCKS - 1) - pop_idx_reg;
    assign lim = (limit_reg > HEAP_BYTES) ? HEAP_BYTES : limit_reg;
    assign bump_end = {2'b00, top_reg} + {1'b0, need_reg};
    assign need17 = need_reg[16:0];
    assign left = hdr_rdata.size - need17;
    assign pay17 = {1'b0, hdr_rdata.offset} + HEADER_BYTES;

    always_comb
    begin
        state_next = state_reg;
        limit_next = limit_reg;
        op_next = op_reg;
        need_next = need_reg;
        faddr_next = faddr_reg;
        cur_next = cur_reg;
        steps_next = steps_reg;
        cur_hdr_next = cur_hdr_reg;
        new_next = new_reg;
        pop_idx_next = pop_idx_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        top_next = top_reg;
        spare_cnt_next = spare_cnt_reg;
        spare_vld_next = spare_vld_reg;
        res_addr_next = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next = out_valid_reg;
        out_addr_next = out_addr_reg;
        out_status_next = out_status_reg;
        hdr_we = 1'b0;
        hdr_waddr = cur_reg[ENTRY_W-1:0];
        hdr_wdata = cur_hdr_reg;
        hdr_re = 1'b0;
        hdr_raddr = cur_reg[ENTRY_W-1:0];
        sp_we = 1'b0;
        sp_waddr = spare_cnt_reg[ENTRY_W-1:0];
        sp_wdata = '0;
        sp_re = 1'b0;
        sp_raddr = pop_idx_reg;

        if (cfg_valid)
        begin
            limit_next = arena_limit;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    need_next = {1'b0, request_bytes} + {1'b0, HEADER_BYTES};
                    faddr_next = free_address;
                    cur_next = head_reg;
                    steps_next = '0;
                    res_addr_next = '0;
                    if ((op == OP_ALLOC && request_bytes == '0)
                        || (op == OP_FREE && free_address == '0))
                    begin
                        res_status_next = ST_NULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (cur_reg[ENTRY_W] || steps_reg == LINK_W'(MAX_BLOCKS))
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        state_next = S_BUMP;
                    end
                    else
                    begin
                        res_status_next = ST_UNKNOWN;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    hdr_re = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cur_hdr_next = hdr_rdata;
                if (op_reg == OP_ALLOC)
                begin
                    if (hdr_rdata.is_free && {1'b0, hdr_rdata.size} >= need_reg)
                    begin
                        res_addr_next = pay17[15:0];
                        res_status_next = ST_OK;
                        if (left >= MIN_BLOCK_BYTES && spare_cnt_reg != '0)
                        begin
                            pop_idx_next = ENTRY_W'(spare_cnt_reg - 1'b1);
                            sp_re = 1'b1;
                            sp_raddr = ENTRY_W'(spare_cnt_reg - 1'b1);
                            state_next = S_SPLIT_POP;
                        end
                        else
                        begin
                            hdr_we = 1'b1;
                            hdr_wdata = hdr_rdata;
                            hdr_wdata.is_free = 1'b0;
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        cur_next = hdr_rdata.next;
                        steps_next = steps_reg + 1'b1;
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    if (pay17 == {1'b0, faddr_reg})
                    begin
                        res_status_next = ST_OK;
                        if (!hdr_rdata.next[ENTRY_W])
                        begin
                            hdr_re = 1'b1;
                            hdr_raddr = hdr_rdata.next[ENTRY_W-1:0];
                            state_next = S_FREE_NX;
                        end
                        else
                        begin
                            hdr_we = 1'b1;
                            hdr_wdata = hdr_rdata;
                            hdr_wdata.is_free = 1'b1;
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        cur_next = hdr_rdata.next;
                        steps_next = steps_reg + 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_SPLIT_POP:
            begin
                spare_cnt_next = spare_cnt_reg - 1'b1;
                new_next = spare_val;
                hdr_we = 1'b1;
                hdr_waddr = spare_val;
                hdr_wdata.offset = cur_hdr_reg.offset + need17[15:0];
                hdr_wdata.size = cur_hdr_reg.size - need17;
                hdr_wdata.is_free = 1'b1;
                hdr_wdata.next = cur_hdr_reg.next;
                if (tail_reg == cur_reg)
                begin
                    tail_next = {1'b0, spare_val};
                end
                state_next = S_SPLIT_WR;
            end
            S_SPLIT_WR:
            begin
                hdr_we = 1'b1;
                hdr_wdata.offset = cur_hdr_reg.offset;
                hdr_wdata.size = need17;
                hdr_wdata.is_free = 1'b0;
                hdr_wdata.next = {1'b0, new_reg};
                state_next = S_FIN;
            end
            S_BUMP:
            begin
                if (bump_end > {2'b00, lim} || spare_cnt_reg == '0)
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next = S_FIN;
                end
                else
                begin
                    pop_idx_next = ENTRY_W'(spare_cnt_reg - 1'b1);
                    sp_re = 1'b1;
                    sp_raddr = ENTRY_W'(spare_cnt_reg - 1'b1);
                    hdr_re = !tail_reg[ENTRY_W];
                    hdr_raddr = tail_reg[ENTRY_W-1:0];
                    state_next = S_BUMP_POP;
                end
            end
            S_BUMP_POP:
            begin
                spare_cnt_next = spare_cnt_reg - 1'b1;
                new_next = spare_val;
                cur_hdr_next = hdr_rdata;
                hdr_we = 1'b1;
                hdr_waddr = spare_val;
                hdr_wdata.offset = top_reg[15:0];
                hdr_wdata.size = need17;
                hdr_wdata.is_free = 1'b0;
                hdr_wdata.next = NONE_ENTRY;
                top_next = bump_end[16:0];
                res_addr_next = 16'(top_reg + HEADER_BYTES);
                res_status_next = ST_OK;
                if (tail_reg[ENTRY_W])
                begin
                    head_next = {1'b0, spare_val};
                    tail_next = {1'b0, spare_val};
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_BUMP_WR;
                end
            end
            S_BUMP_WR:
            begin
                hdr_we = 1'b1;
                hdr_waddr = tail_reg[ENTRY_W-1:0];
                hdr_wdata = cur_hdr_reg;
                hdr_wdata.next = {1'b0, new_reg};
                tail_next = {1'b0, new_reg};
                state_next = S_FIN;
            end
            S_FREE_NX:
            begin
                hdr_we = 1'b1;
                hdr_wdata = cur_hdr_reg;
                hdr_wdata.is_free = 1'b1;
                if (hdr_rdata.is_free)
                begin
                    hdr_wdata.size = cur_hdr_reg.size + hdr_rdata.size;
                    hdr_wdata.next = hdr_rdata.next;
                    if (tail_reg == cur_hdr_reg.next)
                    begin
                        tail_next = cur_reg;
                    end
                    if (spare_cnt_reg < LINK_W'(MAX_BLOCKS))
                    begin
                        sp_we = 1'b1;
                        sp_wdata = cur_hdr_reg.next[ENTRY_W-1:0];
                        spare_vld_next[spare_cnt_reg[ENTRY_W-1:0]] = 1'b1;
                        spare_cnt_next = spare_cnt_reg + 1'b1;
                    end
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next = (res_status_reg == ST_OK) ? res_addr_reg : '0;
                    out_status_next = res_status_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= HEAP_BYTES;
            head_reg <= NONE_ENTRY;
            tail_reg <= NONE_ENTRY;
            top_reg <= '0;
            spare_cnt_reg <= LINK_W'(MAX_BLOCKS);
            spare_vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            limit_reg <= limit_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            top_reg <= top_next;
            spare_cnt_reg <= spare_cnt_next;
            spare_vld_reg <= spare_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        need_reg <= need_next;
        faddr_reg <= faddr_next;
        cur_reg <= cur_next;
        steps_reg <= steps_next;
        cur_hdr_reg <= cur_hdr_next;
        new_reg <= new_next;
        pop_idx_reg <= pop_idx_next;
        res_addr_reg <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule
